// ===== sv/lruc_pkg.sv =====
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lruc_pkg;

  // Operation carried by an input word
  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lruc_cmd_t;

  // Capacity register
  localparam int          CAP_W     = 5;
  localparam int unsigned CAP_RESET = 16;

  // Status from the lookup logic to the update logic
  typedef struct packed {
    logic hit;           // key present in a valid entry
    logic full;          // entries in use reached the capacity
    logic victim_found;  // a valid entry holds the oldest rank
    logic free_found;    // an entry is unused
  } lruc_look_t;

endpackage

// ===== sv/lruc_req_if.sv =====
// ----------------------------------------------------------------------------
// lruc_req_if
// Request channel: command, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface lruc_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  lruc_pkg::lruc_cmd_t          cmd;
  logic signed [DATA_WIDTH-1:0] key;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

// ===== sv/lruc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lruc_rsp_if
// Response channel: hit, read value and eviction report with valid/ready.
// ----------------------------------------------------------------------------
interface lruc_rsp_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [DATA_WIDTH-1:0] read_value;
  logic                         evicted;
  logic signed [DATA_WIDTH-1:0] evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

// ===== sv/lruc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lruc_cfg_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
interface lruc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lruc_pkg::CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lru_key_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// Each request word (get or put) is captured in an input register, looked up
// against all entries in one pass of parallel key compares, and its response
// plus the entry update land together at the next edge in the result
// register and the entry flops. A new word is taken every cycle unless a
// held response (out_ch.ready low) stalls the input register; throughput is
// one word per clock, set by the single lookup/update pass; every request
// sees the state left by the request before it. A get hit returns the stored
// value and makes the entry most recent; a get miss returns -1. A put hit
// overwrites the value and refreshes recency; a put miss inserts the key as
// most recent, first evicting the oldest entry (reported in evicted_key)
// when the entries in use have reached the capacity. Capacity writes of zero
// act as one and values above ENTRIES act as ENTRIES; lowering capacity
// drops nothing at once, later put misses evict before inserting. The config
// channel is always ready and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
  parameter int ENTRIES    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lruc_cfg_if.sink   cfg_ch,
  lruc_req_if.sink   in_ch,
  lruc_rsp_if.source out_ch
);
  import lruc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] CAP_INIT =
    CW'((CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET);

  // --------------------------------------------------------------------------
  // Capacity register, stored already clamped to 1..ENTRIES
  // --------------------------------------------------------------------------
  logic [CW-1:0] cap_r, cap_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (cfg_ch.data == '0) begin
      cap_nxt = CW'(1);
    end else if (int'(cfg_ch.data) > ENTRIES) begin
      cap_nxt = CW'(ENTRIES);
    end else begin
      cap_nxt = CW'(cfg_ch.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_INIT;
    end else if (cfg_ch.valid) begin
      cap_r <= cap_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Input register and handshake
  // --------------------------------------------------------------------------
  logic                  stg_valid_r;
  lruc_cmd_t             stg_cmd_r;
  logic [DATA_WIDTH-1:0] stg_key_r;
  logic [DATA_WIDTH-1:0] stg_val_r;
  logic                  out_valid_r;
  logic                  adv;       // staged word is processed this cycle

  assign adv         = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_cmd_r <= in_ch.cmd;
      stg_key_r <= in_ch.key;
      stg_val_r <= in_ch.value;
    end
  end

  // --------------------------------------------------------------------------
  // Entry state: valid bits and age ranks reset, keys and values do not.
  // Rank 0 is most recent; valid ranks are 0..count-1, all distinct.
  // --------------------------------------------------------------------------
  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [IW-1:0]         rank_r   [ENTRIES];
  logic [IW-1:0]         rank_nxt [ENTRIES];
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] key_r    [ENTRIES];
  logic [DATA_WIDTH-1:0] val_r    [ENTRIES];

  // single write port for key/value storage
  logic                  wr_key_en;
  logic                  wr_val_en;
  logic [IW-1:0]         wr_idx;

  // --------------------------------------------------------------------------
  // Lookup
  // --------------------------------------------------------------------------
  lruc_look_t         look;
  logic [ENTRIES-1:0] match_vec;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      victim_idx;
  logic [IW-1:0]      free_idx;

  lruc_lookup #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_lookup (
    .valid_vec  (valid_r),
    .keys       (key_r),
    .ranks      (rank_r),
    .count      (count_r),
    .cap        (cap_r),
    .key        (stg_key_r),
    .look       (look),
    .match_vec  (match_vec),
    .hit_idx    (hit_idx),
    .victim_idx (victim_idx),
    .free_idx   (free_idx)
  );

  // --------------------------------------------------------------------------
  // Update and response
  // --------------------------------------------------------------------------
  logic                  is_put;
  logic                  do_evict;   // put miss with full cache and an oldest entry
  logic                  do_insert;  // put miss that finds a slot
  logic [IW-1:0]         ins_idx;
  logic [IW-1:0]         hit_rank;

  logic                  out_hit_r;
  logic [DATA_WIDTH-1:0] out_rv_r;
  logic                  out_ev_r;
  logic [DATA_WIDTH-1:0] out_evk_r;
  logic [DATA_WIDTH-1:0] rv_nxt;
  logic [DATA_WIDTH-1:0] evk_nxt;

  assign is_put    = (stg_cmd_r == CMD_PUT);
  assign do_evict  = is_put && !look.hit && look.full && look.victim_found;
  assign do_insert = is_put && !look.hit && (do_evict || look.free_found);
  assign ins_idx   = do_evict ? victim_idx : free_idx;
  assign hit_rank  = rank_r[hit_idx];

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;
    wr_key_en = 1'b0;
    wr_val_en = 1'b0;
    wr_idx    = hit_idx;
    if (adv) begin
      if (look.hit) begin
        // promote: younger entries age by one, hit entry becomes newest
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (IW'(i) != hit_idx) && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        rank_nxt[hit_idx] = '0;
        wr_val_en         = is_put;
      end else if (do_insert) begin
        // all surviving entries age by one, new entry is newest
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && !(do_evict && (IW'(i) == victim_idx))) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        valid_nxt[ins_idx] = 1'b1;
        rank_nxt[ins_idx]  = '0;
        wr_key_en          = 1'b1;
        wr_val_en          = 1'b1;
        wr_idx             = ins_idx;
        if (!do_evict) begin
          count_nxt = count_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_r[wr_idx] <= stg_key_r;
    end
    if (wr_val_en) begin
      val_r[wr_idx] <= stg_val_r;
    end
  end

  always_comb begin
    if (is_put) begin
      rv_nxt = '0;
    end else if (look.hit) begin
      rv_nxt = val_r[hit_idx];
    end else begin
      rv_nxt = '1;  // get miss reads as -1
    end
    evk_nxt = do_evict ? key_r[victim_idx] : '0;
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= look.hit;
      out_rv_r  <= rv_nxt;
      out_ev_r  <= do_evict;
      out_evk_r <= evk_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.read_value  = out_rv_r;
  assign out_ch.evicted     = out_ev_r;
  assign out_ch.evicted_key = out_evk_r;

`ifndef SYNTHESIS
  // fill count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid bits");

  // a key sits in at most one valid entry
  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r |-> $onehot0(match_vec))
    else $error("key matched in more than one entry");

  // a put miss on a full cache always finds the oldest entry to evict
  a_victim_exists: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_put && !look.hit && look.full) |-> look.victim_found)
    else $error("no oldest entry found on full put miss");

  // a put miss always finds a slot
  a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_put && !look.hit) |-> do_insert)
    else $error("put miss found no slot");

  // response word appears the cycle after a word is processed
  a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed word produced no response");
`endif

endmodule

// ===== sv/lruc_lookup.sv =====
// ----------------------------------------------------------------------------
// lruc_lookup
// Parallel key compare, oldest-entry search and free-entry search.
// ----------------------------------------------------------------------------
module lruc_lookup #(
  parameter int ENTRIES    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic [ENTRIES-1:0]              valid_vec,
  input  logic [DATA_WIDTH-1:0]           keys [ENTRIES],
  input  logic [$clog2(ENTRIES)-1:0]      ranks [ENTRIES],
  input  logic [$clog2(ENTRIES+1)-1:0]    count,
  input  logic [$clog2(ENTRIES+1)-1:0]    cap,
  input  logic [DATA_WIDTH-1:0]           key,
  output lruc_pkg::lruc_look_t            look,
  output logic [ENTRIES-1:0]              match_vec,
  output logic [$clog2(ENTRIES)-1:0]      hit_idx,
  output logic [$clog2(ENTRIES)-1:0]      victim_idx,
  output logic [$clog2(ENTRIES)-1:0]      free_idx
);
  import lruc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] oldest_vec;
  logic [CW-1:0]      oldest_rank;

  assign oldest_rank = count - CW'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i]  = valid_vec[i] && (keys[i] == key);
      oldest_vec[i] = valid_vec[i] && (CW'(ranks[i]) == oldest_rank);
    end
  end

  // lowest index wins in each search
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IW'(i);
      end
      if (oldest_vec[i]) begin
        victim_idx = IW'(i);
      end
      if (!valid_vec[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    look.hit          = |match_vec;
    look.full         = (count >= cap);
    look.victim_found = |oldest_vec;
    look.free_found   = ~&valid_vec;
  end

endmodule
